>>> design/bspline_knot_span_search_macros.svh
// assertion macros for the knot span search block
`ifndef BSPLINE_KNOT_SPAN_SEARCH_MACROS_SVH
`define BSPLINE_KNOT_SPAN_SEARCH_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BKSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bkss assertion failed");

// next-cycle implication
`define BKSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bkss assertion failed");

`else

`define BKSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BKSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/bkss_pkg.sv
`default_nettype none

package bkss_pkg;

    localparam int MAX_KNOTS  = 64;
    localparam int MAX_DEGREE = 7;

    localparam int IDX_W  = $clog2(MAX_KNOTS);
    localparam int SIDX_W = IDX_W + 2;
    localparam int DEG_W  = 3;
    localparam int KC_W   = 7;
    localparam int DATA_W = 32;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [DEG_W-1:0] DEGREE_RST     = 3'd3;
    localparam logic [KC_W-1:0]  KNOT_COUNT_RST = 7'd8;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic REG_DEGREE     = 1'b0;
    localparam logic REG_KNOT_COUNT = 1'b1;

    localparam logic [1:0] RD_N    = 2'd0;
    localparam logic [1:0] RD_P    = 2'd1;
    localparam logic [1:0] RD_MID  = 2'd2;
    localparam logic [1:0] RD_MID1 = 2'd3;

    localparam logic [2:0] SPAN_KEEP  = 3'd0;
    localparam logic [2:0] SPAN_SMALL = 3'd1;
    localparam logic [2:0] SPAN_NM1   = 3'd2;
    localparam logic [2:0] SPAN_P     = 3'd3;
    localparam logic [2:0] SPAN_MID   = 3'd4;

    typedef struct packed {
        logic       wr_en;
        logic       ld;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       mid_ld;
        logic       init_range;
        logic       hi_dn;
        logic       lo_up;
        logic [2:0] span_sel;
        logic       emit_init;
        logic       emit_step;
    } t_cmd;

    typedef struct packed {
        logic n_le_p;
        logic x_ge_k;
        logic x_le_k;
        logic lo_le_hi;
        logic span_neg;
        logic idx_last;
    } t_stat;

endpackage

`default_nettype wire

>>> design/bkss_regs.sv
`default_nettype none

module bkss_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [bkss_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [bkss_pkg::APB_W-1:0]  i_pwdata,
    output logic      [bkss_pkg::APB_W-1:0]  o_prdata,
    output logic      [bkss_pkg::DEG_W-1:0]  o_degree,
    output logic      [bkss_pkg::KC_W-1:0]   o_knot_count
);
    import bkss_pkg::*;

    logic [DEG_W-1:0] r_degree;
    logic [KC_W-1:0]  r_knot_count;
    logic             w_wr;
    logic             w_sel;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_sel = i_paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree     <= DEGREE_RST;
            r_knot_count <= KNOT_COUNT_RST;
        end else if (w_wr) begin
            case (w_sel)
                REG_DEGREE:     r_degree     <= i_pwdata[DEG_W-1:0];
                REG_KNOT_COUNT: r_knot_count <= i_pwdata[KC_W-1:0];
                default:        r_degree     <= r_degree;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_DEGREE:     o_prdata = APB_W'(r_degree);
            REG_KNOT_COUNT: o_prdata = APB_W'(r_knot_count);
            default:        o_prdata = '0;
        endcase
    end

    assign o_degree     = r_degree;
    assign o_knot_count = r_knot_count;

endmodule

`default_nettype wire

>>> design/bkss_ctrl.sv
`default_nettype none

module bkss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_func,
    input  wire bkss_pkg::t_stat i_stat,
    output bkss_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);
    import bkss_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_CMP_N     = 4'd2;
    localparam logic [3:0] S_CMP_P     = 4'd3;
    localparam logic [3:0] S_MID       = 4'd4;
    localparam logic [3:0] S_CMP_MID   = 4'd5;
    localparam logic [3:0] S_CMP_MID1  = 4'd6;
    localparam logic [3:0] S_EMIT_INIT = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_func == FUNC_LOAD) begin
                    o_cmd.wr_en = 1'b1;
                end else if (i_start && i_func == FUNC_QUERY) begin
                    o_cmd.ld = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.n_le_p) begin
                    o_cmd.span_sel = SPAN_SMALL;
                    n_state        = S_EMIT_INIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_N;
                    n_state      = S_CMP_N;
                end
            end
            S_CMP_N: begin
                if (i_stat.x_ge_k) begin
                    o_cmd.span_sel = SPAN_NM1;
                    n_state        = S_EMIT_INIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_P;
                    n_state      = S_CMP_P;
                end
            end
            S_CMP_P: begin
                if (i_stat.x_le_k) begin
                    o_cmd.span_sel = SPAN_P;
                    n_state        = S_EMIT_INIT;
                end else begin
                    o_cmd.init_range = 1'b1;
                    n_state          = S_MID;
                end
            end
            S_MID: begin
                if (i_stat.lo_le_hi) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    o_cmd.mid_ld = 1'b1;
                    n_state      = S_CMP_MID;
                end else begin
                    o_cmd.span_sel = SPAN_P;
                    n_state        = S_EMIT_INIT;
                end
            end
            S_CMP_MID: begin
                if (!i_stat.x_ge_k) begin
                    o_cmd.hi_dn = 1'b1;
                    n_state     = S_MID;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID1;
                    n_state      = S_CMP_MID1;
                end
            end
            S_CMP_MID1: begin
                if (i_stat.x_ge_k) begin
                    o_cmd.lo_up = 1'b1;
                    n_state     = S_MID;
                end else begin
                    o_cmd.span_sel = SPAN_MID;
                    n_state        = S_EMIT_INIT;
                end
            end
            S_EMIT_INIT: begin
                o_cmd.emit_init = 1'b1;
                n_state = i_stat.span_neg ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);

endmodule

`default_nettype wire

>>> design/bkss_dp.sv
`default_nettype none

module bkss_dp (
    input  wire logic                             i_clk,
    input  wire bkss_pkg::t_cmd                   i_cmd,
    input  wire logic        [bkss_pkg::IDX_W-1:0]  i_knot_index,
    input  wire logic signed [bkss_pkg::DATA_W-1:0] i_knot_value,
    input  wire logic signed [bkss_pkg::DATA_W-1:0] i_x,
    input  wire logic        [bkss_pkg::DEG_W-1:0]  i_degree,
    input  wire logic        [bkss_pkg::KC_W-1:0]   i_knot_count,
    output bkss_pkg::t_stat                       o_stat,
    output logic             [bkss_pkg::IDX_W-1:0]  o_basis_index,
    output logic             [bkss_pkg::IDX_W-1:0]  o_span,
    output logic                                  o_last
);
    import bkss_pkg::*;

    logic        [DATA_W-1:0] r_mem [MAX_KNOTS];
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] r_x;
    logic        [DEG_W-1:0]  r_p;
    logic        [KC_W-1:0]   r_m;
    logic signed [SIDX_W-1:0] r_lo;
    logic signed [SIDX_W-1:0] r_hi;
    logic signed [SIDX_W-1:0] r_mid;
    logic signed [SIDX_W-1:0] r_span;
    logic        [IDX_W-1:0]  r_idx;

    logic signed [SIDX_W-1:0] w_p;
    logic signed [SIDX_W-1:0] w_n;
    logic signed [SIDX_W-1:0] w_mm1;
    logic signed [SIDX_W:0]   w_sum;
    logic signed [SIDX_W-1:0] w_mid;
    logic signed [SIDX_W-1:0] w_mid1;
    logic        [IDX_W-1:0]  w_rd_addr;
    logic signed [SIDX_W-1:0] w_span_nxt;
    logic        [DEG_W-1:0]  w_deg_sat;
    logic        [KC_W-1:0]   w_kc_sat;

    // saturate configuration to the table limits
    assign w_deg_sat = (i_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : i_degree;
    assign w_kc_sat  = (i_knot_count > KC_W'(MAX_KNOTS)) ? KC_W'(MAX_KNOTS) : i_knot_count;

    assign w_p    = SIDX_W'(r_p);
    assign w_mm1  = SIDX_W'(r_m) - SIDX_W'(1);
    assign w_n    = w_mm1 - w_p;
    assign w_sum  = {r_lo[SIDX_W-1], r_lo} + {r_hi[SIDX_W-1], r_hi};
    assign w_mid  = w_sum[SIDX_W:1];
    assign w_mid1 = r_mid + SIDX_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_N:    w_rd_addr = w_n[IDX_W-1:0];
            RD_P:    w_rd_addr = IDX_W'(r_p);
            RD_MID:  w_rd_addr = w_mid[IDX_W-1:0];
            RD_MID1: w_rd_addr = w_mid1[IDX_W-1:0];
            default: w_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_knot_index] <= i_knot_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.span_sel)
            SPAN_SMALL: w_span_nxt = (w_mm1 < w_p) ? w_mm1 : w_p;
            SPAN_NM1:   w_span_nxt = w_n - SIDX_W'(1);
            SPAN_P:     w_span_nxt = w_p;
            SPAN_MID:   w_span_nxt = r_mid;
            default:    w_span_nxt = r_span;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_x <= i_x;
            r_p <= w_deg_sat;
            r_m <= w_kc_sat;
        end
        if (i_cmd.mid_ld) begin
            r_mid <= w_mid;
        end
        if (i_cmd.init_range) begin
            r_lo <= w_p;
            r_hi <= w_n - SIDX_W'(1);
        end else if (i_cmd.hi_dn) begin
            r_hi <= r_mid - SIDX_W'(1);
        end else if (i_cmd.lo_up) begin
            r_lo <= w_mid1;
        end
        r_span <= w_span_nxt;
        if (i_cmd.emit_init) begin
            r_idx <= (r_span >= w_p) ? (r_span[IDX_W-1:0] - IDX_W'(r_p)) : '0;
        end else if (i_cmd.emit_step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_stat.n_le_p   = (w_n <= w_p);
    assign o_stat.x_ge_k   = (r_x >= r_rdata);
    assign o_stat.x_le_k   = (r_x <= r_rdata);
    assign o_stat.lo_le_hi = (r_lo <= r_hi);
    assign o_stat.span_neg = r_span[SIDX_W-1];
    assign o_stat.idx_last = (r_idx == r_span[IDX_W-1:0]);

    assign o_basis_index = r_idx;
    assign o_span        = r_span[IDX_W-1:0];
    assign o_last        = (r_idx == r_span[IDX_W-1:0]);

endmodule

`default_nettype wire

>>> design/bspline_knot_span_search.sv
// B-spline knot span search over a writable table of signed Q16.16 knots.
// Items enter on start while busy is low. A load (func 0) writes knot_value
// at knot_index in the accepting cycle; busy stays low and there is no result.
// A query (func 1) raises busy, locates the knot span of x for the configured
// degree p and then emits beats on o_valid, one per cycle: basis indices
// span-p .. span in increasing order, each with the span, o_last on the final
// beat. Indices below 0 are dropped; with knot_count zero a query
// gives no beat. busy falls in the cycle after the last beat.
// Query steps: a setup state, up to two end checks, then bisection steps that
// read the knot at mid and, if needed, at mid+1, and a last range check if the
// range runs empty, all bound by the single read port of the knot memory, then
// an emit setup state before the first beat and at most p+1 beats.
// degree and knot_count are written over the APB port at 0x0 and 0x4; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Synchronous reset returns to idle with degree 3 and
// knot_count 8; the knot table is not cleared and must be loaded before use.
// Results cannot be stalled: each beat is valid for one cycle only.
`default_nettype none

`include "bspline_knot_span_search_macros.svh"

module bspline_knot_span_search (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_func,
    input  wire logic        [bkss_pkg::IDX_W-1:0]  i_knot_index,
    input  wire logic signed [bkss_pkg::DATA_W-1:0] i_knot_value,
    input  wire logic signed [bkss_pkg::DATA_W-1:0] i_x,
    output logic                                   o_valid,
    output logic             [bkss_pkg::IDX_W-1:0]  o_basis_index,
    output logic             [bkss_pkg::IDX_W-1:0]  o_span,
    output logic                                   o_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic        [bkss_pkg::ADDR_W-1:0] paddr,
    input  wire logic        [bkss_pkg::APB_W-1:0]  pwdata,
    output logic             [bkss_pkg::APB_W-1:0]  prdata,
    output logic                                   pready
);
    import bkss_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [DEG_W-1:0] w_degree;
    logic [KC_W-1:0]  w_knot_count;

    assign pready = 1'b1;

    bkss_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_degree     (w_degree),
        .o_knot_count (w_knot_count)
    );

    bkss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    bkss_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_knot_index  (i_knot_index),
        .i_knot_value  (i_knot_value),
        .i_x           (i_x),
        .i_degree      (w_degree),
        .i_knot_count  (w_knot_count),
        .o_stat        (w_stat),
        .o_basis_index (o_basis_index),
        .o_span        (o_span),
        .o_last        (o_last)
    );

    `BKSS_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `BKSS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_func == FUNC_QUERY, busy)
    `BKSS_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last, !o_valid && !busy)
    `BKSS_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !o_last,
                      o_valid && (o_basis_index == $past(o_basis_index) + IDX_W'(1)))
    `BKSS_ASSERT_NOW(a_idx_le_span, i_clk, i_rst_n, o_valid, o_basis_index <= o_span)

endmodule

`default_nettype wire
